>>> rtl/glyph_to_pixel_stream_top_defines.svh
// Assertion macros for the glyph to pixel stream block.
// Used by the port checker; needs clk_i and rst_ni in the including scope.
`ifndef GLYPH_TO_PIXEL_STREAM_TOP_DEFINES_SVH
`define GLYPH_TO_PIXEL_STREAM_TOP_DEFINES_SVH

// Implication that must hold in the same cycle.
`define G2P_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Implication checked in the next cycle.
`define G2P_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/g2p_pkg.sv
// Shared types, codes and the 5x8 font table of the glyph to pixel stream block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package g2p_pkg;

  localparam logic [7:0] GlyphFirst = 8'h20;
  localparam logic [7:0] GlyphLast  = 8'h7A;
  localparam logic [7:0] GlyphSubst = 8'h3F;

  localparam logic [7:0] OpColumn   = 8'h15;
  localparam logic [7:0] OpRow      = 8'h75;
  localparam logic [7:0] OpMemWrite = 8'h5C;

  localparam logic [1:0] KindCmd   = 2'd0;
  localparam logic [1:0] KindData  = 2'd1;
  localparam logic [1:0] KindPixel = 2'd2;

  localparam int unsigned NumGlyphs = 91;
  localparam int unsigned SeqLen    = 55;

  typedef logic [6:0] glyph_idx_t;
  typedef logic [39:0] glyph_bits_t;

  typedef struct packed {
    logic       en;
    glyph_idx_t addr;
  } rom_req_t;

  // Column 0 in the top byte, column 4 in the low byte; bit 0 of a byte is the top row.
  localparam glyph_bits_t FontRom [NumGlyphs] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001C224100, 40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
    40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
    40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
    40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
    40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
    40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h081454543C,
    40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
    40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040407C, 40'h1C2040201C, 40'h3C4030403C,
    40'h4428102844, 40'h0C5050503C, 40'h4464544C44
  };

endpackage

`default_nettype wire

>>> rtl/g2p_font_rom.sv
// Synchronous font memory; the read data is registered.
// Depends on g2p_pkg for the font table and the read request type.
`timescale 1ns / 1ps
`default_nettype none

module g2p_font_rom (
  input  wire logic              clk_i,
  input  wire g2p_pkg::rom_req_t req_i,
  output logic [39:0]            data_o
);
  import g2p_pkg::*;

  glyph_bits_t mem [NumGlyphs];
  glyph_bits_t data_q;

  assign mem = FontRom;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      data_q <= mem[req_i.addr];
    end
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

>>> rtl/g2p_sequencer.sv
// Item sequencer: holds one character, issues the font read and steps through
// the window words and the 48 pixel words into an output register.
// Depends on g2p_pkg.
`timescale 1ns / 1ps
`default_nettype none

module g2p_sequencer (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [7:0]        char_code_i,
  input  wire logic [6:0]        pos_x_i,
  input  wire logic [6:0]        pos_y_i,
  input  wire logic [15:0]       fg_color_i,
  input  wire logic [15:0]       bg_color_i,
  output g2p_pkg::rom_req_t      rom_req_o,
  input  wire logic [39:0]       rom_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [1:0]             item_kind_o,
  output logic [15:0]            value_o,
  output logic                   last_item_o
);
  import g2p_pkg::*;

  localparam logic [5:0] CntLast   = 6'(SeqLen - 1);
  localparam logic [5:0] CntPixel0 = 6'd7;

  logic        busy_q, busy_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [2:0]  row_q, row_d;
  logic [2:0]  col_q, col_d;
  logic [6:0]  px_q, py_q;
  logic [15:0] fg_q, bg_q;
  logic        ovalid_q, ovalid_d;
  logic [1:0]  okind_q, okind_d;
  logic [15:0] ovalue_q, ovalue_d;
  logic        olast_q, olast_d;

  logic        gen_fire, last_gen, accept, pix_on;
  logic [7:0]  code_sel;
  logic [2:0]  col_rev;

  always_comb begin
    gen_fire   = busy_q && (!ovalid_q || out_ready_i);
    last_gen   = (cnt_q == CntLast);
    in_ready_o = !busy_q || (gen_fire && last_gen);
    accept     = in_valid_i && in_ready_o;

    code_sel = ((char_code_i < GlyphFirst) || (char_code_i > GlyphLast)) ? GlyphSubst
                                                                        : char_code_i;
    rom_req_o.en   = accept;
    rom_req_o.addr = 7'(code_sel - GlyphFirst);

    col_rev = 3'd4 - col_q;
    pix_on  = (col_q < 3'd5) && rom_data_i[{col_rev, row_q}];

    busy_d   = busy_q;
    cnt_d    = cnt_q;
    row_d    = row_q;
    col_d    = col_q;
    ovalid_d = ovalid_q;
    okind_d  = okind_q;
    ovalue_d = ovalue_q;
    olast_d  = olast_q;

    if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
    if (gen_fire) begin
      ovalid_d = 1'b1;
      olast_d  = 1'b0;
      cnt_d    = cnt_q + 6'd1;
      case (cnt_q)
        6'd0: begin
          okind_d  = KindCmd;
          ovalue_d = {8'h00, OpColumn};
        end
        6'd1: begin
          okind_d  = KindData;
          ovalue_d = {9'h000, px_q};
        end
        6'd2: begin
          okind_d  = KindData;
          ovalue_d = {8'h00, {1'b0, px_q} + 8'd5};
        end
        6'd3: begin
          okind_d  = KindCmd;
          ovalue_d = {8'h00, OpRow};
        end
        6'd4: begin
          okind_d  = KindData;
          ovalue_d = {9'h000, py_q};
        end
        6'd5: begin
          okind_d  = KindData;
          ovalue_d = {8'h00, {1'b0, py_q} + 8'd7};
        end
        6'd6: begin
          okind_d  = KindCmd;
          ovalue_d = {8'h00, OpMemWrite};
        end
        default: begin
          okind_d  = KindPixel;
          ovalue_d = pix_on ? fg_q : bg_q;
          olast_d  = last_gen;
        end
      endcase
      if (cnt_q >= CntPixel0) begin
        if (col_q == 3'd5) begin
          col_d = 3'd0;
          row_d = row_q + 3'd1;
        end else begin
          col_d = col_q + 3'd1;
        end
      end
      if (last_gen) begin
        busy_d = 1'b0;
      end
    end
    if (accept) begin
      busy_d = 1'b1;
      cnt_d  = 6'd0;
      row_d  = 3'd0;
      col_d  = 3'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      cnt_q    <= 6'd0;
      row_q    <= 3'd0;
      col_q    <= 3'd0;
      ovalid_q <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      cnt_q    <= cnt_d;
      row_q    <= row_d;
      col_q    <= col_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    okind_q  <= okind_d;
    ovalue_q <= ovalue_d;
    olast_q  <= olast_d;
    if (accept) begin
      px_q <= pos_x_i;
      py_q <= pos_y_i;
      fg_q <= fg_color_i;
      bg_q <= bg_color_i;
    end
  end

  assign out_valid_o = ovalid_q;
  assign item_kind_o = okind_q;
  assign value_o     = ovalue_q;
  assign last_item_o = olast_q;

endmodule

`default_nettype wire

>>> rtl/glyph_to_pixel_stream_top.sv
// Top level of the glyph to pixel stream block: stream ports, field packing.
// Depends on g2p_pkg, g2p_font_rom and g2p_sequencer.
//
//   Channel  Dir  tdata                  tuser       tlast
//   s_axis   in   code,x,y,fg,bg (56b)   -           -
//   m_axis   out  value (16b)            item_kind   last_item
//
// Each character gives 55 output words, one per cycle while m_axis does not stall,
// set by the sequence counter that drives the single output register.
// The next character is taken in the cycle its last pixel word is produced.
// The font memory is read once per character, in the cycle it is accepted.
// A stall on m_axis holds the output word and pauses the sequence.
// Reset clears the sequencer's busy flag, counter, row and column, and the output valid flag.
`timescale 1ns / 1ps
`default_nettype none

module glyph_to_pixel_stream_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // char_code[7:0], pos_x[14:8], pos_y[21:15], fg_color[37:22], bg_color[53:38], zero pad
  input  wire logic [55:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // value[15:0]
  output logic [15:0]      m_axis_tdata_o,
  // item_kind[1:0]
  output logic [1:0]       m_axis_tuser_o,
  output logic             m_axis_tlast_o
);
  import g2p_pkg::*;

  rom_req_t    rom_req;
  glyph_bits_t rom_data;

  g2p_font_rom u_rom (
    .clk_i  (clk_i),
    .req_i  (rom_req),
    .data_o (rom_data)
  );

  g2p_sequencer u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .char_code_i (s_axis_tdata_i[7:0]),
    .pos_x_i     (s_axis_tdata_i[14:8]),
    .pos_y_i     (s_axis_tdata_i[21:15]),
    .fg_color_i  (s_axis_tdata_i[37:22]),
    .bg_color_i  (s_axis_tdata_i[53:38]),
    .rom_req_o   (rom_req),
    .rom_data_i  (rom_data),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .item_kind_o (m_axis_tuser_o),
    .value_o     (m_axis_tdata_o),
    .last_item_o (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

>>> rtl/g2p_checker.sv
// Port-level checker for the glyph to pixel stream block, bound to the top level.
// Depends on g2p_pkg and glyph_to_pixel_stream_top_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "glyph_to_pixel_stream_top_defines.svh"

module g2p_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [15:0] m_axis_tdata_o,
  input wire logic [1:0]  m_axis_tuser_o,
  input wire logic        m_axis_tlast_o
);
  import g2p_pkg::*;

  `G2P_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o), "stalled output word changed")
  `G2P_ASSERT_NOW(a_last_is_pixel, m_axis_tvalid_o && m_axis_tlast_o, m_axis_tuser_o == KindPixel, "last flag on a non-pixel word")
  `G2P_ASSERT_NOW(a_kind_legal, m_axis_tvalid_o, m_axis_tuser_o == KindCmd || m_axis_tuser_o == KindData || m_axis_tuser_o == KindPixel, "illegal item kind")
  `G2P_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "input ready right after an accept")

endmodule

bind glyph_to_pixel_stream_top g2p_checker u_chk (.*);

`default_nettype wire
